/* rtl/core/tbcd_pkg.sv */
// Shared types and constants for the touch button click detector.
package tbcd_pkg;

   localparam int CHARGE_W = 24;
   localparam int MS_W     = 16;
   localparam int STAMP_W  = 32;
   localparam int SUM_W    = 32;
   localparam int CNT_W    = 16;
   localparam int CLICK_W  = 8;
   localparam int KIND_W   = 2;
   localparam int ADDR_W   = 2;
   localparam int DATA_W   = 24;

   localparam logic [ADDR_W-1:0] CSR_THRESHOLD  = 2'd0;
   localparam logic [ADDR_W-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [ADDR_W-1:0] CSR_CLICK_GAP  = 2'd2;
   localparam logic [ADDR_W-1:0] CSR_EVAL_IVAL  = 2'd3;

   localparam logic [CHARGE_W-1:0] THRESHOLD_RST  = 24'd350;
   localparam logic [MS_W-1:0]     LONG_PRESS_RST = 16'd500;
   localparam logic [MS_W-1:0]     CLICK_GAP_RST  = 16'd250;
   localparam logic [MS_W-1:0]     EVAL_IVAL_RST  = 16'd25;

   localparam logic [KIND_W-1:0] EV_CLICK      = 2'd0;
   localparam logic [KIND_W-1:0] EV_HOLD_START = 2'd1;
   localparam logic [KIND_W-1:0] EV_HOLDING    = 2'd2;

   localparam logic [CLICK_W-1:0] CLICK_RST = 8'd1;
   localparam logic [CLICK_W-1:0] CLICK_MAX = 8'hFF;
   localparam logic [CNT_W-1:0]   CNT_MAX   = 16'hFFFF;

   typedef struct packed {
      logic idle;
      logic accum;
      logic div_start;
      logic apply;
      logic emit;
   } tbcd_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic failed;
      logic eval_due;
      logic div_done;
      logic has_result;
      logic out_full;
   } tbcd_sts_type;

endpackage

/* rtl/core/tbcd_if.sv */
// Channel interfaces: sample input, event output, register write.
interface tbcd_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] charge_time;
   logic        sample_failed;
   logic [31:0] now_ms;
   modport source (output valid, charge_time, sample_failed, now_ms, input ready);
   modport sink (input valid, charge_time, sample_failed, now_ms, output ready);
endinterface

interface tbcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [7:0] click_count;
   modport source (output valid, event_kind, click_count, input ready);
   modport sink (input valid, event_kind, click_count, output ready);
endinterface

interface tbcd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [23:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

/* rtl/core/tbcd_div.sv */
// Restoring divider, one quotient bit per cycle, for the sample average.
module tbcd_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tbcd_pkg::SUM_W-1:0] dividend,
   input  logic [tbcd_pkg::CNT_W-1:0] divisor,
   output logic                       done,
   output logic [tbcd_pkg::SUM_W-1:0] quotient
);
   import tbcd_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   logic [SUM_W-1:0]  dq_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W:0]    rem_sh;
   logic [CNT_W+1:0]  diff;
   logic              fits;
   logic [CNT_W-1:0]  rem_in;

   always_comb begin
      rem_sh = {rem_ff, dq_ff[SUM_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};
      fits   = ~diff[CNT_W+1];
      rem_in = fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         dq_ff  <= {dq_ff[SUM_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

/* rtl/core/tbcd_ctrl.sv */
// Controller state machine sequencing one sample item through the datapath.
module tbcd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  tbcd_pkg::tbcd_sts_type sts,
   output tbcd_pkg::tbcd_cmd_type cmd
);
   import tbcd_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ACCUM  = 6'b000010,
      ST_START  = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_APPLY  = 6'b010000,
      ST_DECIDE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (sts.req_valid) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (sts.failed) begin
               state_in = ST_IDLE;
            end else begin
               cmd.accum = 1'b1;
               state_in  = sts.eval_due ? ST_START : ST_DECIDE;
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!sts.has_result) begin
               state_in = ST_IDLE;
            end else if (!sts.out_full) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/tbcd_dp.sv */
// Datapath: registers, sample accumulation, press tracking and event output.
module tbcd_dp #(
   parameter int TIME_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   tbcd_req_if.sink               req,
   tbcd_rsp_if.source             rsp,
   tbcd_csr_if.sink               csr,
   input  tbcd_pkg::tbcd_cmd_type cmd,
   output tbcd_pkg::tbcd_sts_type sts
);
   import tbcd_pkg::*;

   logic [CHARGE_W-1:0] thr_ff;
   logic [MS_W-1:0]     long_ff;
   logic [MS_W-1:0]     gap_ff;
   logic [MS_W-1:0]     ival_ff;

   logic [CHARGE_W-1:0]  charge_ff;
   logic                 failed_ff;
   logic [TIME_BITS-1:0] now_ff;

   logic                 pressed_ff, pressed_in;
   logic                 pend_ff, pend_in;
   logic [CLICK_W-1:0]   clicks_ff, clicks_in;
   logic [TIME_BITS-1:0] press_t_ff, press_t_in;
   logic [TIME_BITS-1:0] rel_t_ff, rel_t_in;
   logic [TIME_BITS-1:0] eval_t_ff, eval_t_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic                 out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [CLICK_W-1:0]   count_ff, count_in;

   logic [SUM_W:0]       sum_wide;
   logic [TIME_BITS-1:0] since_eval, since_press, since_rel;
   logic                 held_long, gap_over;
   logic                 click_hit, hold_hit;
   logic                 div_done;
   logic [SUM_W-1:0]     avg;

   tbcd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (avg)
   );

   assign req.ready = cmd.idle;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THRESHOLD_RST;
         long_ff <= LONG_PRESS_RST;
         gap_ff  <= CLICK_GAP_RST;
         ival_ff <= EVAL_IVAL_RST;
      end else if (csr.valid) begin
         unique case (csr.addr)
            CSR_THRESHOLD:  thr_ff  <= csr.data;
            CSR_LONG_PRESS: long_ff <= csr.data[MS_W-1:0];
            CSR_CLICK_GAP:  gap_ff  <= csr.data[MS_W-1:0];
            CSR_EVAL_IVAL:  ival_ff <= csr.data[MS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && cmd.idle) begin
         charge_ff <= req.charge_time;
         failed_ff <= req.sample_failed;
         now_ff    <= TIME_BITS'(req.now_ms);
      end
   end

   always_comb begin
      since_eval  = now_ff - eval_t_ff;
      since_press = now_ff - press_t_ff;
      since_rel   = now_ff - rel_t_ff;
      held_long   = since_press > TIME_BITS'(long_ff);
      gap_over    = since_rel > TIME_BITS'(gap_ff);
      sum_wide    = {1'b0, sum_ff} + {{(SUM_W-CHARGE_W+1){1'b0}}, charge_ff};
      click_hit   = !pressed_ff && (clicks_ff != '0) && gap_over;
      hold_hit    = pressed_ff && held_long;
   end

   always_comb begin
      pressed_in   = pressed_ff;
      pend_in      = pend_ff;
      clicks_in    = clicks_ff;
      press_t_in   = press_t_ff;
      rel_t_in     = rel_t_ff;
      eval_t_in    = eval_t_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      kind_in      = kind_ff;
      count_in     = count_ff;

      if (cmd.accum) begin
         sum_in = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
         if (cnt_ff != CNT_MAX) cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.apply) begin
         if (pressed_ff && (avg < SUM_W'(thr_ff))) begin
            pressed_in = 1'b0;
            pend_in    = 1'b0;
            if (held_long) begin
               clicks_in = '0;
            end else if (clicks_ff != CLICK_MAX) begin
               clicks_in = clicks_ff + 1'b1;
            end
            rel_t_in = now_ff;
         end else if (!pressed_ff && (avg > SUM_W'(thr_ff))) begin
            pressed_in = 1'b1;
            pend_in    = 1'b1;
            press_t_in = now_ff;
         end
         sum_in    = '0;
         cnt_in    = '0;
         eval_t_in = now_ff;
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         count_in     = clicks_ff;
         if (click_hit) begin
            kind_in   = EV_CLICK;
            clicks_in = '0;
         end else begin
            kind_in = pend_ff ? EV_HOLD_START : EV_HOLDING;
            pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         clicks_ff    <= CLICK_RST;
         press_t_ff   <= '0;
         rel_t_ff     <= '0;
         eval_t_ff    <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pressed_ff   <= pressed_in;
         pend_ff      <= pend_in;
         clicks_ff    <= clicks_in;
         press_t_ff   <= press_t_in;
         rel_t_ff     <= rel_t_in;
         eval_t_ff    <= eval_t_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      count_ff <= count_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.event_kind  = kind_ff;
   assign rsp.click_count = count_ff;

   always_comb begin
      sts            = '0;
      sts.req_valid  = req.valid;
      sts.failed     = failed_ff;
      sts.eval_due   = since_eval >= TIME_BITS'(ival_ff);
      sts.div_done   = div_done;
      sts.has_result = click_hit || hold_hit;
      sts.out_full   = out_valid_ff && !rsp.ready;
   end

endmodule

/* rtl/core/touch_button_click_detector_top.sv */
// Top level: touch button click detector, controller plus datapath.
// A failed sample goes from the accumulate state straight back to idle; a sample with no
// evaluation passes accumulate and decide; an evaluating one adds start, the 32-step divider and apply.
// Throughput: one item at a time; the next item is accepted once the last returns to idle.
// An event waits in the output register; a new event stalls only while it is still full.
// Reset (synchronous, active high) loads register defaults and the startup click count of one.
module touch_button_click_detector_top #(
   parameter int TIME_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   tbcd_req_if.sink   req_port,
   tbcd_rsp_if.source rsp_port,
   tbcd_csr_if.sink   csr_port
);
   import tbcd_pkg::*;

   tbcd_cmd_type cmd;
   tbcd_sts_type sts;

   tbcd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   tbcd_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_port),
      .rsp   (rsp_port),
      .csr   (csr_port),
      .cmd   (cmd),
      .sts   (sts)
   );

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("controller stayed idle after taking an item");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_port.valid)
      else $error("emitted event not presented");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (sts.has_result && !sts.out_full))
      else $error("event emitted without result or into a full slot");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> !req_port.ready)
      else $error("divider finished while controller idle");

endmodule

/* tb/touch_event_checker.sv */
`timescale 1ns / 1ps
// Event checker: predicts the detector's button events from observed samples and compares them.
module touch_event_checker (
   input  logic clock,
   input  logic reset,
   tbcd_req_if  req_mon,
   tbcd_rsp_if  rsp_mon,
   tbcd_csr_if  csr_mon,
   output int   error_count,
   output int   events_due
);
   import tbcd_pkg::*;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CLICK_W-1:0] count;
   } button_event_type;

   button_event_type expected_events [$];

   logic [CHARGE_W-1:0] touch_level;
   logic [MS_W-1:0]     long_press;
   logic [MS_W-1:0]     click_gap;
   logic [MS_W-1:0]     eval_gap;

   logic                touched;
   logic                hold_start_due;
   logic [CLICK_W-1:0]  click_tally;
   logic [STAMP_W-1:0]  press_stamp;
   logic [STAMP_W-1:0]  release_stamp;
   logic [STAMP_W-1:0]  eval_stamp;
   logic [SUM_W-1:0]    charge_total;
   logic [CNT_W-1:0]    charge_samples;

   function automatic void predict_touch_event(input logic [CHARGE_W-1:0] charge,
                                               input logic failed,
                                               input logic [STAMP_W-1:0] at_ms);
      logic [SUM_W:0]     widened;
      logic [SUM_W-1:0]   average;
      logic [STAMP_W-1:0] since_eval;
      logic [STAMP_W-1:0] since_press;
      logic [STAMP_W-1:0] since_release;
      if (failed) return;
      widened = {1'b0, charge_total} + SUM_W'(charge);
      charge_total = widened[SUM_W] ? '1 : widened[SUM_W-1:0];
      if (charge_samples != CNT_MAX) charge_samples = charge_samples + 1'b1;
      since_eval = at_ms - eval_stamp;
      if (since_eval >= STAMP_W'(eval_gap)) begin
         if (charge_samples == '0) return;
         average = charge_total / SUM_W'(charge_samples);
         if (touched && average < SUM_W'(touch_level)) begin
            touched = 1'b0;
            hold_start_due = 1'b0;
            since_press = at_ms - press_stamp;
            if (since_press > STAMP_W'(long_press)) begin
               click_tally = '0;
            end else if (click_tally != CLICK_MAX) begin
               click_tally = click_tally + 1'b1;
            end
            release_stamp = at_ms;
         end else if (!touched && average > SUM_W'(touch_level)) begin
            touched = 1'b1;
            hold_start_due = 1'b1;
            press_stamp = at_ms;
         end
         charge_total = '0;
         charge_samples = '0;
         eval_stamp = at_ms;
      end
      since_release = at_ms - release_stamp;
      since_press = at_ms - press_stamp;
      if (!touched && click_tally != '0 && since_release > STAMP_W'(click_gap)) begin
         expected_events.push_back(button_event_type'{EV_CLICK, click_tally});
         click_tally = '0;
      end else if (touched && since_press > STAMP_W'(long_press)) begin
         expected_events.push_back(
            button_event_type'{hold_start_due ? EV_HOLD_START : EV_HOLDING, click_tally});
         hold_start_due = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      button_event_type wanted;
      int               fails;
      fails = 0;
      if (reset) begin
         touch_level = THRESHOLD_RST;
         long_press = LONG_PRESS_RST;
         click_gap = CLICK_GAP_RST;
         eval_gap = EVAL_IVAL_RST;
         touched = 1'b0;
         hold_start_due = 1'b0;
         click_tally = CLICK_RST;
         press_stamp = '0;
         release_stamp = '0;
         eval_stamp = '0;
         charge_total = '0;
         charge_samples = '0;
         expected_events.delete();
         error_count <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.addr)
               CSR_THRESHOLD: touch_level = csr_mon.data[CHARGE_W-1:0];
               CSR_LONG_PRESS: long_press = csr_mon.data[MS_W-1:0];
               CSR_CLICK_GAP: click_gap = csr_mon.data[MS_W-1:0];
               CSR_EVAL_IVAL: eval_gap = csr_mon.data[MS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected event, expected none, actual kind %0d count %0d",
                        $time, rsp_mon.event_kind, rsp_mon.click_count);
               fails++;
            end else begin
               wanted = expected_events.pop_front();
               if (rsp_mon.event_kind !== wanted.kind) begin
                  $display("%0t: event_kind expected %0d actual %0d",
                           $time, wanted.kind, rsp_mon.event_kind);
                  fails++;
               end
               if (rsp_mon.click_count !== wanted.count) begin
                  $display("%0t: click_count expected %0d actual %0d",
                           $time, wanted.count, rsp_mon.click_count);
                  fails++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_touch_event(req_mon.charge_time, req_mon.sample_failed, req_mon.now_ms);
         end
         error_count <= error_count + fails;
      end
      events_due <= expected_events.size();
   end

endmodule

/* tb/touch_button_click_detector_top_test.sv */
`timescale 1ns / 1ps
// Test top: drives touch samples and register writes into the click detector and gives the verdict.
module touch_button_click_detector_top_test;
   import tbcd_pkg::*;

   localparam int HOLDOFF_CYCLES = 600;
   localparam int SETTLE_CYCLES  = 60;
   localparam int RANDOM_ITEMS   = 850;
   localparam int GESTURES       = 30;
   localparam logic [CHARGE_W-1:0] CHARGE_TOP = '1;

   typedef struct packed {
      logic [CHARGE_W-1:0] charge;
      logic                failed;
      logic [STAMP_W-1:0]  at_ms;
   } touch_sample_type;

   touch_sample_type opening [18] = '{
      '{24'd0,       1'b0, 32'd0},
      '{24'hFFFFFF,  1'b1, 32'hFFFFFFFF},
      '{24'd0,       1'b0, 32'd300},
      '{24'hFFFFFF,  1'b0, 32'd330},
      '{24'hFFFFFF,  1'b0, 32'd900},
      '{24'hFFFFFF,  1'b0, 32'd910},
      '{24'd0,       1'b0, 32'd935},
      '{24'd0,       1'b0, 32'd970},
      '{24'd350,     1'b0, 32'd1000},
      '{24'd1000,    1'b0, 32'd1030},
      '{24'd0,       1'b0, 32'd1060},
      '{24'd351,     1'b0, 32'd1090},
      '{24'd349,     1'b0, 32'd1120},
      '{24'd0,       1'b0, 32'd1400},
      '{24'hFFFFFF,  1'b0, 32'hFFFFFFF0},
      '{24'd0,       1'b0, 32'hFFFFFFFF},
      '{24'd0,       1'b0, 32'h00000100},
      '{24'd0,       1'b0, 32'h00000300}
   };

   logic clock;
   logic reset;
   logic idle_on     = 1'b1;
   logic holdoff_req = 1'b0;
   int   error_count;
   int   events_due;
   int   sample_items = 0;

   logic [STAMP_W-1:0]  stamp;
   logic [CHARGE_W-1:0] cur_thr;
   logic [MS_W-1:0]     cur_long;
   logic [MS_W-1:0]     cur_gap;
   logic [MS_W-1:0]     cur_ival;

   tbcd_req_if req_if ();
   tbcd_rsp_if rsp_if ();
   tbcd_csr_if csr_if ();

   touch_button_click_detector_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   touch_event_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_mon     (csr_if),
      .error_count (error_count),
      .events_due  (events_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      bit held_off;
      held_off = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_req && !held_off) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            held_off = 1'b1;
         end else begin
            rsp_if.ready <= !(idle_on && $urandom_range(99) < 37);
         end
      end
   end

   task automatic offer_sample(input logic [CHARGE_W-1:0] charge, input logic failed,
                               input logic [STAMP_W-1:0] at_ms);
      while (idle_on && $urandom_range(99) < 37) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.charge_time <= charge;
      req_if.sample_failed <= failed;
      req_if.now_ms <= at_ms;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (!failed) sample_items++;
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (events_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.addr <= addr;
      csr_if.data <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   task automatic write_settings(input logic [CHARGE_W-1:0] thr, input logic [MS_W-1:0] long_ms,
                                 input logic [MS_W-1:0] gap_ms, input logic [MS_W-1:0] ival_ms);
      write_register(CSR_THRESHOLD, DATA_W'(thr));
      write_register(CSR_LONG_PRESS, DATA_W'(long_ms));
      write_register(CSR_CLICK_GAP, DATA_W'(gap_ms));
      write_register(CSR_EVAL_IVAL, DATA_W'(ival_ms));
      csr_if.valid <= 1'b0;
      cur_thr = thr;
      cur_long = long_ms;
      cur_gap = gap_ms;
      cur_ival = ival_ms;
   endtask

   function automatic logic [CHARGE_W-1:0] charge_above();
      if (cur_thr == CHARGE_TOP || $urandom_range(9) == 0) return CHARGE_TOP;
      return CHARGE_W'($urandom_range(CHARGE_TOP, cur_thr + 1));
   endfunction

   function automatic logic [CHARGE_W-1:0] charge_below();
      if (cur_thr == '0 || $urandom_range(9) == 0) return '0;
      return CHARGE_W'($urandom_range(cur_thr - 1, 0));
   endfunction

   task automatic touch_sample(input logic [CHARGE_W-1:0] charge, input int unsigned step);
      if ($urandom_range(99) < 6) offer_sample(CHARGE_W'($urandom()), 1'b1, $urandom());
      if ($urandom_range(99) < 8) begin
         offer_sample(CHARGE_W'($urandom()), 1'b0, stamp + $urandom_range(0, cur_ival - 1));
      end
      stamp += step;
      offer_sample(charge, 1'b0, stamp);
   endtask

   task automatic click_gesture();
      int held;
      int quiet;
      held = $urandom_range(1, 6);
      quiet = $urandom_range(0, 4);
      repeat (held) touch_sample(charge_above(), cur_ival + $urandom_range(0, cur_long / 3));
      touch_sample(charge_below(), cur_ival + $urandom_range(0, cur_long / 3));
      repeat (quiet) touch_sample(charge_below(), cur_ival + $urandom_range(0, cur_gap / 2));
   endtask

   task automatic noise_burst();
      int n;
      n = $urandom_range(1, 5);
      repeat (n) begin
         if ($urandom_range(99) < 4) stamp = $urandom();
         else stamp += $urandom_range(0, 2 * cur_ival + cur_gap);
         offer_sample(CHARGE_W'($urandom()), $urandom_range(99) < 25, stamp);
      end
   endtask

   initial begin
      int random_start;
      int phase;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.charge_time <= '0;
      req_if.sample_failed <= 1'b0;
      req_if.now_ms <= '0;
      csr_if.valid <= 1'b0;
      csr_if.addr <= CSR_THRESHOLD;
      csr_if.data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_settings(THRESHOLD_RST, LONG_PRESS_RST, CLICK_GAP_RST, EVAL_IVAL_RST);
      foreach (opening[k]) offer_sample(opening[k].charge, opening[k].failed, opening[k].at_ms);
      stamp = opening[17].at_ms;

      // hold the button while the receiver stalls
      holdoff_req <= 1'b1;
      repeat (30) begin
         stamp += 32'd600;
         offer_sample(CHARGE_TOP, 1'b0, stamp);
      end
      settle();

      // drive the rapid-click count into saturation
      write_settings(24'd1000, 16'hFFFF, 16'hFFFF, 16'd1);
      stamp += 32'h10000;
      offer_sample('0, 1'b0, stamp);
      repeat (260) begin
         stamp += 32'd1;
         offer_sample(24'd5000, 1'b0, stamp);
         stamp += 32'd1;
         offer_sample('0, 1'b0, stamp);
      end
      stamp += 32'h10000;
      offer_sample('0, 1'b0, stamp);
      settle();

      // saturate the sample sum
      idle_on = 1'b0;
      write_settings(24'd5000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      stamp += 32'd70000;
      offer_sample('0, 1'b0, stamp);
      stamp += 32'hFFFF;
      offer_sample('0, 1'b0, stamp);
      repeat (300) offer_sample(CHARGE_TOP, 1'b0, stamp);
      stamp += 32'hFFFF;
      offer_sample(CHARGE_TOP, 1'b0, stamp);
      settle();
      idle_on = 1'b1;

      random_start = sample_items;
      phase = 0;
      while (sample_items - random_start < RANDOM_ITEMS) begin
         case (phase)
            0: write_settings('0, 16'd1, 16'd1, 16'd1);
            1: write_settings(CHARGE_TOP, '1, '1, '1);
            default: begin
               write_settings(($urandom_range(3) == 0) ? CHARGE_W'($urandom())
                                                       : CHARGE_W'($urandom_range(1, 5000)),
                              MS_W'($urandom_range(1, 1500)), MS_W'($urandom_range(1, 800)),
                              MS_W'($urandom_range(1, 100)));
            end
         endcase
         stamp = $urandom();
         repeat (GESTURES) begin
            if ($urandom_range(99) < 75) click_gesture();
            else noise_burst();
         end
         settle();
         phase++;
      end

      if (error_count == 0 && events_due == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/tbcd_pkg.sv
rtl/core/tbcd_if.sv
rtl/core/tbcd_div.sv
rtl/core/tbcd_ctrl.sv
rtl/core/tbcd_dp.sv
rtl/core/touch_button_click_detector_top.sv
tb/touch_event_checker.sv
tb/touch_button_click_detector_top_test.sv
